[hdl/sparse_axis_value_store_top_defines.svh]
// assertion macros for the sparse axis value store
// used by sparse_axis_value_store_top, expects clk and rst_n in scope
`ifndef SPARSE_AXIS_VALUE_STORE_TOP_DEFINES_SVH
`define SPARSE_AXIS_VALUE_STORE_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define SVS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/svs_pkg.sv]
// shared constants, types and helpers of the sparse axis value store
// no dependencies
package svs_pkg;

    localparam int MAX_STORED = 32;
    localparam int AXES       = 64;
    localparam int AXIS_W     = 6;
    localparam int VALUE_W    = 32;
    localparam int ADDR_W     = (MAX_STORED > 1) ? $clog2(MAX_STORED) : 1;
    localparam int COUNT_W    = $clog2(MAX_STORED + 1);
    localparam int RANK_W     = AXIS_W;
    localparam int CMP_W      = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;
    localparam int CHUNK_W    = 8;
    localparam int CBIT_W     = $clog2(CHUNK_W);
    localparam int NUM_CHUNKS = AXES / CHUNK_W;
    localparam int CIDX_W     = $clog2(NUM_CHUNKS);
    localparam int CPOP_W     = $clog2(CHUNK_W + 1);

    localparam logic [VALUE_W-1:0] MAG_MASK = 32'h7FFF_FFFF;

    typedef enum logic [0:0] {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MEM,
        RES_FULL
    } res_sel_t;

    typedef struct packed {
        logic     latch;
        logic     scan;
        logic     shift_init;
        logic     rd_shift;
        logic     wr_shift;
        logic     rd_rank;
        logic     wr_rank;
        logic     insert;
        logic     set_result;
        res_sel_t res_sel;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic               scan_last;
        logic               is_write;
        logic               present;
        logic               zero_value;
        logic               full;
        logic               shift_more;
        logic               out_free;
        logic [COUNT_W-1:0] count;
    } dp_sts_t;

    function automatic logic [CPOP_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] bits);
        logic [CPOP_W-1:0] n;
        n = '0;
        for (int j = 0; j < CHUNK_W; j++)
        begin
            n = n + CPOP_W'(bits[j]);
        end
        return n;
    endfunction

endpackage

[hdl/svs_ctrl.sv]
// sequencer of the sparse axis value store: scan, shift, insert, result
// depends on svs_pkg
module svs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  svs_pkg::dp_sts_t sts,
    output svs_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.res_sel = svs_pkg::RES_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (!sts.is_write && sts.present)
                begin
                    cmd.rd_rank = 1'b1;
                    state_next  = S_RD_DATA;
                end
                else if (!sts.is_write || sts.present || sts.zero_value)
                begin
                    // absent read, overwrite, or skipped zero
                    cmd.wr_rank    = sts.is_write && sts.present;
                    cmd.set_result = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = svs_pkg::RES_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK:
            begin
                if (sts.shift_more)
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    cmd.insert     = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_RD_DATA:
            begin
                cmd.set_result = 1'b1;
                cmd.res_sel    = svs_pkg::RES_MEM;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[hdl/svs_datapath.sv]
// mask, fill count, rank scan, packed value memory and output register
// depends on svs_pkg
module svs_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        command,
    input  logic [svs_pkg::AXIS_W-1:0]  axis,
    input  logic [svs_pkg::VALUE_W-1:0] write_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [svs_pkg::VALUE_W-1:0] read_value,
    output logic                        status,
    input  svs_pkg::dp_cmd_t            cmd,
    output svs_pkg::dp_sts_t            sts
);

    logic [svs_pkg::AXES-1:0]     mask_reg;
    logic [svs_pkg::COUNT_W-1:0]  count_reg;
    svs_pkg::command_t            cmd_reg;
    logic [svs_pkg::AXIS_W-1:0]   axis_reg;
    logic [svs_pkg::VALUE_W-1:0]  value_reg;
    logic [svs_pkg::RANK_W-1:0]   rank_reg;
    logic [svs_pkg::CIDX_W-1:0]   chunk_reg;
    logic [svs_pkg::COUNT_W-1:0]  idx_reg;
    logic [svs_pkg::VALUE_W-1:0]  mem_rdata_reg;
    logic [svs_pkg::VALUE_W-1:0]  res_data_reg;
    logic                         res_status_reg;
    logic                         out_valid_reg;
    logic [svs_pkg::VALUE_W-1:0]  read_value_reg;
    logic                         status_reg;

    logic [svs_pkg::VALUE_W-1:0]  mem [svs_pkg::MAX_STORED];

    logic [svs_pkg::CHUNK_W-1:0]  chunk_bits;
    logic [svs_pkg::CHUNK_W-1:0]  below;
    logic [svs_pkg::RANK_W-1:0]   rank_next;
    logic [svs_pkg::COUNT_W-1:0]  idx_m1;
    logic                         mem_re;
    logic                         mem_we;
    logic [svs_pkg::ADDR_W-1:0]   rd_addr;
    logic [svs_pkg::ADDR_W-1:0]   wr_addr;
    logic [svs_pkg::VALUE_W-1:0]  wr_data;

    // one byte of the mask per scan cycle, counting only axes below the target
    always_comb
    begin
        chunk_bits = mask_reg[{chunk_reg, svs_pkg::CBIT_W'(0)} +: svs_pkg::CHUNK_W];
        for (int j = 0; j < svs_pkg::CHUNK_W; j++)
        begin
            below[j] = ({chunk_reg, svs_pkg::CBIT_W'(j)} < axis_reg);
        end
        rank_next = rank_reg
                  + svs_pkg::RANK_W'(svs_pkg::popcount_chunk(chunk_bits & below));
    end

    assign idx_m1 = idx_reg - svs_pkg::COUNT_W'(1);

    assign mem_re  = cmd.rd_shift || cmd.rd_rank;
    assign rd_addr = cmd.rd_shift ? idx_m1[svs_pkg::ADDR_W-1:0]
                                  : rank_reg[svs_pkg::ADDR_W-1:0];
    assign mem_we  = cmd.wr_shift || cmd.wr_rank || cmd.insert;
    assign wr_addr = cmd.wr_shift ? idx_reg[svs_pkg::ADDR_W-1:0]
                                  : rank_reg[svs_pkg::ADDR_W-1:0];
    assign wr_data = cmd.wr_shift ? mem_rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            mem_rdata_reg <= mem[rd_addr];
    end

    // item payload, shift index, result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= svs_pkg::command_t'(command);
            axis_reg  <= axis;
            value_reg <= write_value;
        end
        if (cmd.shift_init)
            idx_reg <= count_reg;
        else if (cmd.wr_shift)
            idx_reg <= idx_m1;
        if (cmd.set_result)
        begin
            unique case (cmd.res_sel)
                svs_pkg::RES_MEM:
                begin
                    res_data_reg   <= mem_rdata_reg;
                    res_status_reg <= 1'b0;
                end
                svs_pkg::RES_FULL:
                begin
                    res_data_reg   <= '0;
                    res_status_reg <= 1'b1;
                end
                default:
                begin
                    res_data_reg   <= '0;
                    res_status_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            read_value_reg <= res_data_reg;
            status_reg     <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            count_reg     <= '0;
            rank_reg      <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                rank_reg  <= '0;
                chunk_reg <= '0;
            end
            else if (cmd.scan)
            begin
                rank_reg  <= rank_next;
                chunk_reg <= chunk_reg + svs_pkg::CIDX_W'(1);
            end
            if (cmd.insert)
            begin
                mask_reg  <= mask_reg | (svs_pkg::AXES'(1) << axis_reg);
                count_reg <= count_reg + svs_pkg::COUNT_W'(1);
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.scan_last  = (chunk_reg == svs_pkg::CIDX_W'(svs_pkg::NUM_CHUNKS - 1));
    assign sts.is_write   = (cmd_reg == svs_pkg::CMD_WRITE);
    assign sts.present    = mask_reg[axis_reg];
    assign sts.zero_value = ((value_reg & svs_pkg::MAG_MASK) == '0);
    assign sts.full       = (count_reg >= svs_pkg::COUNT_W'(svs_pkg::MAX_STORED));
    assign sts.shift_more = (svs_pkg::CMP_W'(idx_reg) > svs_pkg::CMP_W'(rank_reg));
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.count      = count_reg;

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

[hdl/sparse_axis_value_store_top.sv]
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// in       | in_valid, in_stall, command,     | in (stall out)
//          | axis, write_value                |
// out      | out_valid, out_stall,            | out (stall in)
//          | read_value, status               |
//
// one word at a time: accept, a scan over the mask byte by byte, a decision state
// and a state that loads the output register before the next accept
// a read adds a memory read state; an insert adds a check and a write state per entry moved up
// reset clears the mask and fill count; the value memory needs no clearing
// a word held in the output register does not block input; the next result keeps
// the input stalled until that register is free
module sparse_axis_value_store_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [svs_pkg::AXIS_W-1:0]  axis,
    input  logic [svs_pkg::VALUE_W-1:0] write_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [svs_pkg::VALUE_W-1:0] read_value,
    output logic                        status
);

    svs_pkg::dp_cmd_t dp_cmd;
    svs_pkg::dp_sts_t dp_sts;

    svs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    svs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .axis        (axis),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .cmd         (dp_cmd),
        .sts         (dp_sts)
    );

`include "sparse_axis_value_store_top_defines.svh"

    `SVS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")
    `SVS_ASSERT_SAME(a_full_reads_zero, out_valid && status, read_value == '0, "refused write data")
    `SVS_ASSERT_SAME(a_count_bound, 1'b1, dp_sts.count <= svs_pkg::COUNT_W'(svs_pkg::MAX_STORED), "count overflow")

endmodule
